[design/assert_macros.svh]
// Assertion macros shared by the RTL. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds on every clock edge
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check a consequence in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[design/ptc_pkg.sv]
package ptc_pkg;

   // Field widths
   localparam int RAW_W      = 24;
   localparam int COEFF_W    = 16;
   localparam int TEMP_W     = 19;
   localparam int PRESS_W    = 32;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Pipeline depth from input register to output register
   localparam int NUM_STAGES = 10;

   // Temperature reference points in 0.01 C
   localparam logic signed [TEMP_W-1:0] TEMP_REF      = 19'sd2000;
   // Offset from (TEMP - 2000) to (TEMP + 1500)
   localparam logic signed [TEMP_W-1:0] TEMP_COLD_OFS = 19'sd3500;

   typedef enum logic [2:0] {
      CSR_SENS        = 3'd0,
      CSR_OFFSET      = 3'd1,
      CSR_SENS_TEMP   = 3'd2,
      CSR_OFFSET_TEMP = 3'd3,
      CSR_REF_TEMP    = 3'd4,
      CSR_TEMP_SLOPE  = 3'd5
   } csr_index_type;

   // Second-order correction band
   typedef struct packed {
      logic cold;    // below 20.00 C
      logic frigid;  // below -15.00 C
   } band_type;

endpackage

[design/ptc_if.sv]
// Input channel: one raw reading pair per item
interface ptc_req_if import ptc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RAW_W-1:0]  raw_pressure;
   logic [RAW_W-1:0]  raw_temperature;

   modport source (output valid, raw_pressure, raw_temperature, input ready);
   modport sink   (input valid, raw_pressure, raw_temperature, output ready);
endinterface

// Result channel: first-order and corrected values per item
interface ptc_rsp_if import ptc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [TEMP_W-1:0]  temp_first;
   logic signed [PRESS_W-1:0] press_first;
   logic signed [TEMP_W-1:0]  temp_comp;
   logic signed [PRESS_W-1:0] press_comp;

   modport source (output valid, temp_first, press_first, temp_comp, press_comp,
                   input ready);
   modport sink   (input valid, temp_first, press_first, temp_comp, press_comp,
                   output ready);
endinterface

[design/pressure_temperature_compensation.sv]
// An accepted item passes through ten register stages before its result is valid.
// Throughput: one item per cycle while rsp is not stalled; a ten-stage multiplier pipeline sets the depth.
// Stalls on rsp fill empty stages first; req ready drops only when all stages hold items.
// Reset (synchronous, active high) empties the pipeline and clears the six
// calibration registers to zero.
`include "assert_macros.svh"

module pressure_temperature_compensation
   import ptc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ptc_req_if.sink               req_chan,
   ptc_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Truncating divide rounding terms
   localparam logic signed [41:0] SLOPE_RND = 42'sd8388607;   // 2^23 - 1
   localparam logic signed [41:0] SENS_RND  = 42'sd255;       // 2^8 - 1
   localparam logic signed [41:0] OFF_RND   = 42'sd127;       // 2^7 - 1
   localparam logic signed [62:0] PROD_RND  = 63'sd2097151;   // 2^21 - 1
   localparam logic signed [41:0] P1_RND    = 42'sd8191;      // 2^13 - 1
   localparam logic signed [42:0] P2_RND    = 43'sd8191;

   // Join the two partial products of raw pressure times a sensitivity
   function automatic logic signed [62:0] join_partials(
      input logic signed [43:0] hi,
      input logic signed [45:0] lo
   );
      logic signed [63:0] sum;
      sum = ($signed({{20{hi[43]}}, hi}) <<< 20) + $signed({{18{lo[45]}}, lo});
      return sum[62:0];
   endfunction

   // ---------------------------------------------------------------
   // Calibration registers
   // ---------------------------------------------------------------
   logic [COEFF_W-1:0] sens_ff, offset_ff, sens_temp_ff;
   logic [COEFF_W-1:0] offset_temp_ff, ref_temp_ff, temp_slope_ff;
   logic               csr_wr;
   csr_index_type      csr_idx;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   // Write a calibration word; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff        <= '0;
         offset_ff      <= '0;
         sens_temp_ff   <= '0;
         offset_temp_ff <= '0;
         ref_temp_ff    <= '0;
         temp_slope_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_SENS:        sens_ff        <= csr_pwdata[COEFF_W-1:0];
            CSR_OFFSET:      offset_ff      <= csr_pwdata[COEFF_W-1:0];
            CSR_SENS_TEMP:   sens_temp_ff   <= csr_pwdata[COEFF_W-1:0];
            CSR_OFFSET_TEMP: offset_temp_ff <= csr_pwdata[COEFF_W-1:0];
            CSR_REF_TEMP:    ref_temp_ff    <= csr_pwdata[COEFF_W-1:0];
            CSR_TEMP_SLOPE:  temp_slope_ff  <= csr_pwdata[COEFF_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back a calibration word
   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         CSR_SENS:        csr_prdata = {16'd0, sens_ff};
         CSR_OFFSET:      csr_prdata = {16'd0, offset_ff};
         CSR_SENS_TEMP:   csr_prdata = {16'd0, sens_temp_ff};
         CSR_OFFSET_TEMP: csr_prdata = {16'd0, offset_temp_ff};
         CSR_REF_TEMP:    csr_prdata = {16'd0, ref_temp_ff};
         CSR_TEMP_SLOPE:  csr_prdata = {16'd0, temp_slope_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline control: a stage advances when empty or when the next advances
   // ---------------------------------------------------------------
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] adv;

   always_comb begin
      adv[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_chan.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_chan.ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[1]) begin
            valid_ff[1] <= req_chan.valid;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stage payload registers
   // ---------------------------------------------------------------
   // stage 1
   logic [RAW_W-1:0]          d1_s1_ff;
   logic signed [24:0]        dt_s1_ff;
   // stage 2
   logic [RAW_W-1:0]          d1_s2_ff;
   logic signed [41:0]        slope_prod_ff, sens_prod_ff, off_prod_ff;
   logic signed [49:0]        dt_sq_ff;
   // stage 3
   logic [RAW_W-1:0]          d1_s3_ff;
   logic signed [18:0]        temp_s3_ff, ltemp_s3_ff;
   logic signed [17:0]        dtemp_s3_ff;
   logic signed [33:0]        sens1_s3_ff;
   logic signed [34:0]        off1_s3_ff;
   logic [16:0]               ti_s3_ff;
   band_type                  band_s3_ff;
   // stage 4
   logic [RAW_W-1:0]          d1_s4_ff;
   logic signed [18:0]        temp_s4_ff;
   logic [16:0]               ti_s4_ff;
   logic signed [33:0]        sens1_s4_ff;
   logic signed [34:0]        off1_s4_ff;
   band_type                  band_s4_ff;
   logic signed [35:0]        sq_s4_ff;
   logic signed [37:0]        lsq_s4_ff;
   logic signed [45:0]        pa_lo_s4_ff;
   logic signed [43:0]        pa_hi_s4_ff;
   // stage 5
   logic [RAW_W-1:0]          d1_s5_ff;
   logic signed [18:0]        temp_s5_ff, temp_comp_s5_ff;
   logic signed [33:0]        sens1_s5_ff;
   logic signed [34:0]        off1_s5_ff;
   logic [37:0]               offi_s5_ff;
   logic [36:0]               sensi_s5_ff;
   logic signed [62:0]        prod1_s5_ff;
   // stage 6
   logic [RAW_W-1:0]          d1_s6_ff;
   logic signed [18:0]        temp_s6_ff, temp_comp_s6_ff;
   logic signed [38:0]        sens2_s6_ff;
   logic signed [39:0]        off2_s6_ff;
   logic signed [41:0]        r1_s6_ff;
   // stage 7
   logic signed [18:0]        temp_s7_ff, temp_comp_s7_ff;
   logic signed [PRESS_W-1:0] press1_s7_ff;
   logic signed [39:0]        off2_s7_ff;
   logic signed [45:0]        pb_lo_s7_ff;
   logic signed [43:0]        pb_hi_s7_ff;
   // stage 8
   logic signed [18:0]        temp_s8_ff, temp_comp_s8_ff;
   logic signed [PRESS_W-1:0] press1_s8_ff;
   logic signed [39:0]        off2_s8_ff;
   logic signed [62:0]        prod2_s8_ff;
   // stage 9
   logic signed [18:0]        temp_s9_ff, temp_comp_s9_ff;
   logic signed [PRESS_W-1:0] press1_s9_ff;
   logic signed [42:0]        r2_s9_ff;
   // stage 10 (output register)
   logic signed [TEMP_W-1:0]  temp_first_ff, temp_comp_ff;
   logic signed [PRESS_W-1:0] press_first_ff, press_comp_ff;

   // ---------------------------------------------------------------
   // Next-value logic
   // ---------------------------------------------------------------
   logic signed [24:0] dt_in;
   logic signed [41:0] slope_prod_in, sens_prod_in, off_prod_in;
   logic signed [49:0] dt_sq_in;

   logic signed [41:0] slope_adj, sens_adj, off_adj;
   logic signed [17:0] dtemp_in;
   logic signed [18:0] temp_in, ltemp_in;
   logic signed [33:0] sens1_in;
   logic signed [34:0] off1_in;
   logic [48:0]        dt_sq_mag;
   logic [50:0]        dt_sq_x3;
   logic [16:0]        ti_in;
   band_type           band_in;

   logic signed [35:0] sq_in;
   logic signed [37:0] lsq_in;
   logic signed [38:0] sens1_ext, sens2_ext;
   logic signed [45:0] pa_lo_in, pb_lo_in;
   logic signed [43:0] pa_hi_in, pb_hi_in;

   logic [33:0]        sq_mag;
   logic [35:0]        lsq_mag;
   logic [35:0]        sq_x3;
   logic [36:0]        sq_x5;
   logic [38:0]        lsq_x7;
   logic [37:0]        lsq_x4;
   logic [37:0]        offi_in;
   logic [36:0]        sensi_in;
   logic signed [18:0] temp_comp_in;

   logic signed [38:0] sens2_in;
   logic signed [39:0] off2_in;
   logic signed [62:0] prod1_adj, prod2_adj;
   logic signed [41:0] r1_in, r1_adj;
   logic signed [42:0] r2_in, r2_adj;
   logic signed [PRESS_W-1:0] press1_in, press2_in;

   // Stage 1: temperature difference from the reference reading
   assign dt_in = $signed({1'b0, req_chan.raw_temperature})
                - $signed({1'b0, ref_temp_ff, 8'd0});

   // Stage 2: the four products on dT
   assign slope_prod_in = dt_s1_ff * $signed({1'b0, temp_slope_ff});
   assign sens_prod_in  = dt_s1_ff * $signed({1'b0, sens_temp_ff});
   assign off_prod_in   = dt_s1_ff * $signed({1'b0, offset_temp_ff});
   assign dt_sq_in      = dt_s1_ff * dt_s1_ff;

   // Stage 3: first-order temperature, SENS, OFF and the temperature correction
   always_comb begin
      slope_adj = slope_prod_ff + (slope_prod_ff[41] ? SLOPE_RND : 42'sd0);
      dtemp_in  = slope_adj[40:23];
      temp_in   = $signed({dtemp_in[17], dtemp_in}) + TEMP_REF;
      ltemp_in  = $signed({dtemp_in[17], dtemp_in}) + TEMP_COLD_OFS;
      band_in.cold   = dtemp_in[17];
      band_in.frigid = ltemp_in[18];

      sens_adj = sens_prod_ff + (sens_prod_ff[41] ? SENS_RND : 42'sd0);
      sens1_in = $signed({3'b0, sens_ff, 15'd0}) + sens_adj[41:8];
      off_adj  = off_prod_ff + (off_prod_ff[41] ? OFF_RND : 42'sd0);
      off1_in  = $signed({3'b0, offset_ff, 16'd0}) + off_adj[41:7];

      // dT^2 is never negative: 3*dT^2/2^33 when cold, dT^2/2^36 otherwise
      dt_sq_mag = dt_sq_ff[48:0];
      dt_sq_x3  = {2'b0, dt_sq_mag} + {1'b0, dt_sq_mag, 1'b0};
      ti_in     = band_in.cold ? dt_sq_x3[49:33] : {4'b0, dt_sq_mag[48:36]};
   end

   // Stage 4: squares for the correction and first-pressure partial products
   always_comb begin
      sq_in     = dtemp_s3_ff * dtemp_s3_ff;
      lsq_in    = ltemp_s3_ff * ltemp_s3_ff;
      sens1_ext = $signed({{5{sens1_s3_ff[33]}}, sens1_s3_ff});
      pa_lo_in  = $signed({1'b0, d1_s3_ff}) * $signed({1'b0, sens1_ext[19:0]});
      pa_hi_in  = $signed({1'b0, d1_s3_ff}) * $signed(sens1_ext[38:20]);
   end

   // Stage 5: band-dependent OFFi and SENSi, corrected temperature
   always_comb begin
      sq_mag  = sq_s4_ff[33:0];
      lsq_mag = lsq_s4_ff[35:0];
      sq_x3   = {2'b0, sq_mag} + {1'b0, sq_mag, 1'b0};
      sq_x5   = {3'b0, sq_mag} + {1'b0, sq_mag, 2'b0};
      lsq_x7  = {lsq_mag, 3'b0} - {3'b0, lsq_mag};
      lsq_x4  = {lsq_mag, 2'b0};
      if (band_s4_ff.cold) begin
         offi_in  = {3'b0, sq_x3[35:1]};
         sensi_in = {3'b0, sq_x5[36:3]};
         if (band_s4_ff.frigid) begin
            offi_in  = offi_in + lsq_x7[37:0];
            sensi_in = sensi_in + lsq_x4[36:0];
         end
      end else begin
         offi_in  = {8'b0, sq_mag[33:4]};
         sensi_in = '0;
      end
      temp_comp_in = temp_s4_ff - $signed({2'b0, ti_s4_ff});
   end

   // Stage 6: corrected SENS and OFF, first pressure before the final scale
   always_comb begin
      sens2_in  = $signed({{5{sens1_s5_ff[33]}}, sens1_s5_ff}) - $signed({2'b0, sensi_s5_ff});
      off2_in   = $signed({{5{off1_s5_ff[34]}}, off1_s5_ff}) - $signed({2'b0, offi_s5_ff});
      prod1_adj = prod1_s5_ff + (prod1_s5_ff[62] ? PROD_RND : 63'sd0);
      r1_in     = prod1_adj[62:21] - $signed({{7{off1_s5_ff[34]}}, off1_s5_ff});
   end

   // Stage 7: first pressure, corrected-pressure partial products
   always_comb begin
      r1_adj    = r1_s6_ff + (r1_s6_ff[41] ? P1_RND : 42'sd0);
      press1_in = $signed({{3{r1_adj[41]}}, r1_adj[41:13]});
      sens2_ext = sens2_s6_ff;
      pb_lo_in  = $signed({1'b0, d1_s6_ff}) * $signed({1'b0, sens2_ext[19:0]});
      pb_hi_in  = $signed({1'b0, d1_s6_ff}) * $signed(sens2_ext[38:20]);
   end

   // Stage 9 and 10: corrected pressure
   always_comb begin
      prod2_adj = prod2_s8_ff + (prod2_s8_ff[62] ? PROD_RND : 63'sd0);
      r2_in     = $signed({prod2_adj[62], prod2_adj[62:21]})
                - $signed({{3{off2_s8_ff[39]}}, off2_s8_ff});
      r2_adj    = r2_s9_ff + (r2_s9_ff[42] ? P2_RND : 43'sd0);
      press2_in = $signed({{2{r2_adj[42]}}, r2_adj[42:13]});
   end

   // Advance each stage's payload with its valid bit
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         d1_s1_ff <= req_chan.raw_pressure;
         dt_s1_ff <= dt_in;
      end
      if (adv[2]) begin
         d1_s2_ff      <= d1_s1_ff;
         slope_prod_ff <= slope_prod_in;
         sens_prod_ff  <= sens_prod_in;
         off_prod_ff   <= off_prod_in;
         dt_sq_ff      <= dt_sq_in;
      end
      if (adv[3]) begin
         d1_s3_ff    <= d1_s2_ff;
         temp_s3_ff  <= temp_in;
         dtemp_s3_ff <= dtemp_in;
         ltemp_s3_ff <= ltemp_in;
         sens1_s3_ff <= sens1_in;
         off1_s3_ff  <= off1_in;
         ti_s3_ff    <= ti_in;
         band_s3_ff  <= band_in;
      end
      if (adv[4]) begin
         d1_s4_ff    <= d1_s3_ff;
         temp_s4_ff  <= temp_s3_ff;
         ti_s4_ff    <= ti_s3_ff;
         sens1_s4_ff <= sens1_s3_ff;
         off1_s4_ff  <= off1_s3_ff;
         band_s4_ff  <= band_s3_ff;
         sq_s4_ff    <= sq_in;
         lsq_s4_ff   <= lsq_in;
         pa_lo_s4_ff <= pa_lo_in;
         pa_hi_s4_ff <= pa_hi_in;
      end
      if (adv[5]) begin
         d1_s5_ff        <= d1_s4_ff;
         temp_s5_ff      <= temp_s4_ff;
         temp_comp_s5_ff <= temp_comp_in;
         sens1_s5_ff     <= sens1_s4_ff;
         off1_s5_ff      <= off1_s4_ff;
         offi_s5_ff      <= offi_in;
         sensi_s5_ff     <= sensi_in;
         prod1_s5_ff     <= join_partials(pa_hi_s4_ff, pa_lo_s4_ff);
      end
      if (adv[6]) begin
         d1_s6_ff        <= d1_s5_ff;
         temp_s6_ff      <= temp_s5_ff;
         temp_comp_s6_ff <= temp_comp_s5_ff;
         sens2_s6_ff     <= sens2_in;
         off2_s6_ff      <= off2_in;
         r1_s6_ff        <= r1_in;
      end
      if (adv[7]) begin
         temp_s7_ff      <= temp_s6_ff;
         temp_comp_s7_ff <= temp_comp_s6_ff;
         press1_s7_ff    <= press1_in;
         off2_s7_ff      <= off2_s6_ff;
         pb_lo_s7_ff     <= pb_lo_in;
         pb_hi_s7_ff     <= pb_hi_in;
      end
      if (adv[8]) begin
         temp_s8_ff      <= temp_s7_ff;
         temp_comp_s8_ff <= temp_comp_s7_ff;
         press1_s8_ff    <= press1_s7_ff;
         off2_s8_ff      <= off2_s7_ff;
         prod2_s8_ff     <= join_partials(pb_hi_s7_ff, pb_lo_s7_ff);
      end
      if (adv[9]) begin
         temp_s9_ff      <= temp_s8_ff;
         temp_comp_s9_ff <= temp_comp_s8_ff;
         press1_s9_ff    <= press1_s8_ff;
         r2_s9_ff        <= r2_in;
      end
      // All results fit their fields over the full input range: no clamp
      if (adv[10]) begin
         temp_first_ff  <= temp_s9_ff;
         temp_comp_ff   <= temp_comp_s9_ff;
         press_first_ff <= press1_s9_ff;
         press_comp_ff  <= press2_in;
      end
   end

   // Drive the result channel from the output register
   assign rsp_chan.valid       = valid_ff[NUM_STAGES];
   assign rsp_chan.temp_first  = temp_first_ff;
   assign rsp_chan.press_first = press_first_ff;
   assign rsp_chan.temp_comp   = temp_comp_ff;
   assign rsp_chan.press_comp  = press_comp_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `ASSERT_IMPL(a_frigid_is_cold, clock, reset, valid_ff[3] && band_s3_ff.frigid, band_s3_ff.cold, "frigid band without cold band")
   `ASSERT_IMPL(a_comp_not_above, clock, reset, valid_ff[5], temp_comp_s5_ff <= temp_s5_ff, "corrected temperature above first-order")
   `ASSERT_NEXT(a_stall_keeps_item, clock, reset, valid_ff[6] && !adv[6], valid_ff[6] && $stable(r1_s6_ff), "stalled stage lost its item")
   `ASSERT_IMPL(a_warm_no_sens_corr, clock, reset, valid_ff[4] && !band_s4_ff.cold, sensi_in == '0 && offi_in[37:30] == '0, "warm band correction out of range")

endmodule

[dv/tb_pressure_temperature_compensation.sv]
module tb_pressure_temperature_compensation;
   import ptc_pkg::*;

   // Register map and arithmetic constants of the compensation
   localparam int     CSR_COUNT      = 6;
   localparam int     REG_STRIDE     = 4;
   localparam longint ROOM_TEMP      = 2000;
   localparam longint FRIGID_TEMP    = -1500;
   localparam longint TEMP_SLOPE_DIV = 64'sd8388608;
   localparam longint PRESS_SENS_DIV = 64'sd2097152;
   localparam longint PRESS_DIV      = 64'sd8192;
   localparam longint COLD_TI_DIV    = 64'sd8589934592;
   localparam longint WARM_TI_DIV    = 64'sd137438953472;
   localparam longint TEMP_HI        = 64'sd262143;
   localparam longint TEMP_LO        = -64'sd262144;
   localparam longint PRESS_HI       = 64'sd2147483647;
   localparam longint PRESS_LO       = -64'sd2147483648;
   localparam int     CYCLE_LIMIT    = 300000;
   localparam int     RANDOM_PHASES  = 8;
   localparam int     PHASE_ITEMS    = 50;
   localparam logic [RAW_W-1:0] RAW_MAX = '1;

   typedef struct packed {
      logic signed [TEMP_W-1:0]  temp_first;
      logic signed [PRESS_W-1:0] press_first;
      logic signed [TEMP_W-1:0]  temp_comp;
      logic signed [PRESS_W-1:0] press_comp;
   } reading_result_type;

   // Holds the calibration copy and the queue of compensated readings to come
   class compensation_board;
      logic [COEFF_W-1:0] coeff [CSR_COUNT];
      reading_result_type expected_readings [$];
      int                 fail_count;

      function new();
         foreach (coeff[i]) coeff[i] = '0;
         fail_count = 0;
      endfunction

      function void load_coeff(int idx, logic [CSR_DATA_W-1:0] value);
         if (idx < CSR_COUNT) coeff[idx] = value[COEFF_W-1:0];
      endfunction

      task flag_mismatch(string msg);
         $display("mismatch: %s", msg);
         fail_count++;
      endtask

      function longint widen(logic [RAW_W-1:0] v);
         return longint'({40'd0, v});
      endfunction

      function longint saturate(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function logic signed [TEMP_W-1:0] temp_field(longint v);
         longint c;
         c = saturate(v, TEMP_LO, TEMP_HI);
         return c[TEMP_W-1:0];
      endfunction

      function logic signed [PRESS_W-1:0] press_field(longint d1, longint sens, longint off);
         longint c;
         c = saturate((d1 * sens / PRESS_SENS_DIV - off) / PRESS_DIV, PRESS_LO, PRESS_HI);
         return c[PRESS_W-1:0];
      endfunction

      // Compute first-order and band-corrected temperature and pressure
      function reading_result_type predict_reading(logic [RAW_W-1:0] p_raw,
                                                   logic [RAW_W-1:0] t_raw);
         longint d1, dt, temp, sens, off, dtemp, ltemp, t_corr, off_corr, sens_corr;
         reading_result_type r;
         d1   = widen(p_raw);
         dt   = widen(t_raw) - widen(coeff[CSR_REF_TEMP]) * 256;
         temp = ROOM_TEMP + dt * widen(coeff[CSR_TEMP_SLOPE]) / TEMP_SLOPE_DIV;
         sens = widen(coeff[CSR_SENS]) * 32768 + widen(coeff[CSR_SENS_TEMP]) * dt / 256;
         off  = widen(coeff[CSR_OFFSET]) * 65536 + widen(coeff[CSR_OFFSET_TEMP]) * dt / 128;
         dtemp = temp - ROOM_TEMP;
         if (temp < ROOM_TEMP) begin
            t_corr    = 3 * dt * dt / COLD_TI_DIV;
            off_corr  = 3 * dtemp * dtemp / 2;
            sens_corr = 5 * dtemp * dtemp / 8;
            if (temp < FRIGID_TEMP) begin
               ltemp     = temp - FRIGID_TEMP;
               off_corr  += 7 * ltemp * ltemp;
               sens_corr += 4 * ltemp * ltemp;
            end
         end else begin
            t_corr    = 2 * dt * dt / WARM_TI_DIV;
            off_corr  = dtemp * dtemp / 16;
            sens_corr = 0;
         end
         r.temp_first  = temp_field(temp);
         r.press_first = press_field(d1, sens, off);
         r.temp_comp   = temp_field(temp - t_corr);
         r.press_comp  = press_field(d1, sens - sens_corr, off - off_corr);
         return r;
      endfunction

      function void note_reading(logic [RAW_W-1:0] p_raw, logic [RAW_W-1:0] t_raw);
         expected_readings.push_back(predict_reading(p_raw, t_raw));
      endfunction

      // Compare one result item with the oldest prediction
      task check_reading(reading_result_type got);
         reading_result_type want;
         if (expected_readings.size() == 0) begin
            flag_mismatch("result item with no reading pending");
            return;
         end
         want = expected_readings.pop_front();
         if (got.temp_first !== want.temp_first)
            flag_mismatch($sformatf("temp_first got %0d want %0d",
                                    got.temp_first, want.temp_first));
         if (got.press_first !== want.press_first)
            flag_mismatch($sformatf("press_first got %0d want %0d",
                                    got.press_first, want.press_first));
         if (got.temp_comp !== want.temp_comp)
            flag_mismatch($sformatf("temp_comp got %0d want %0d",
                                    got.temp_comp, want.temp_comp));
         if (got.press_comp !== want.press_comp)
            flag_mismatch($sformatf("press_comp got %0d want %0d",
                                    got.press_comp, want.press_comp));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   bit                    steady = 1'b0;
   int                    cycle_count = 0;
   reading_result_type    seen;
   compensation_board     sb = new();

   ptc_req_if req_chan ();
   ptc_rsp_if rsp_chan ();

   pressure_temperature_compensation u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Stall the result side in random bursts
   initial begin
      rsp_chan.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (!steady && $urandom_range(0, 9) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // Check every accepted result item
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.temp_first  = rsp_chan.temp_first;
         seen.press_first = rsp_chan.press_first;
         seen.temp_comp   = rsp_chan.temp_comp;
         seen.press_comp  = rsp_chan.press_comp;
         sb.check_reading(seen);
      end
   end

   // One APB transfer: setup cycle, then access until pready
   task automatic csr_access(input int idx, input logic write_op,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write_op;
      csr_paddr   = CSR_ADDR_W'(idx * REG_STRIDE);
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic write_coeff(input int idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(idx, 1'b1, value, unused);
      sb.load_coeff(idx, value);
   endtask

   // Read back all calibration words
   task automatic verify_coeffs();
      logic [CSR_DATA_W-1:0] rd;
      for (int idx = 0; idx < CSR_COUNT; idx++) begin
         csr_access(idx, 1'b0, '0, rd);
         if (rd !== {16'd0, sb.coeff[idx]})
            sb.flag_mismatch($sformatf("register %0d read %0h want %0h",
                                       idx, rd, sb.coeff[idx]));
      end
   endtask

   // Offer one reading pair, with an occasional gap ahead of it
   task automatic send_reading(input logic [RAW_W-1:0] p_raw, input logic [RAW_W-1:0] t_raw);
      @(negedge clock);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_chan.valid           = 1'b1;
      req_chan.raw_pressure    = p_raw;
      req_chan.raw_temperature = t_raw;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_reading(p_raw, t_raw);
   endtask

   // Drop valid and wait for every pending result
   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (sb.expected_readings.size() != 0) @(posedge clock);
   endtask

   function automatic logic [COEFF_W-1:0] pick_coeff();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return COEFF_W'($urandom);
      endcase
   endfunction

   // Mostly temperatures near the reference point, spread over all bands
   function automatic logic [RAW_W-1:0] pick_temperature(logic [COEFF_W-1:0] ref_word);
      longint v;
      int span;
      if ($urandom_range(0, 2) == 0) return RAW_W'($urandom);
      span = $urandom_range(4, 23);
      v = longint'({48'd0, ref_word}) * 256;
      if ($urandom_range(0, 1) == 0) v = v + $urandom_range(0, (1 << span) - 1);
      else v = v - $urandom_range(0, (1 << span) - 1);
      if (v < 0) v = 0;
      if (v > longint'({40'd0, RAW_MAX})) v = longint'({40'd0, RAW_MAX});
      return v[RAW_W-1:0];
   endfunction

   initial begin
      logic [RAW_W-1:0] band_points [8];
      logic [RAW_W-1:0] p_raw;
      band_points = '{24'd8388608, 24'd8388352, 24'd8388864, 24'd7492608,
                      24'd7492352, 24'd3000000, 24'd0, RAW_MAX};
      req_chan.valid           = 1'b0;
      req_chan.raw_pressure    = '0;
      req_chan.raw_temperature = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Reset calibration: all words zero
      verify_coeffs();
      send_reading('0, '0);
      send_reading(RAW_MAX, RAW_MAX);
      send_reading(24'h800000, 24'h7FFFFF);
      drain();

      // Reference at mid scale, 256 raw counts per 0.01 C: walk the band edges
      write_coeff(CSR_REF_TEMP, 32'hA5A5_8000);
      write_coeff(CSR_TEMP_SLOPE, 32'h0000_8000);
      write_coeff(CSR_SENS, 32'd40000);
      write_coeff(CSR_OFFSET, 32'hFFFF_7530);
      write_coeff(CSR_SENS_TEMP, 32'd25000);
      write_coeff(CSR_OFFSET_TEMP, 32'd20000);
      write_coeff(CSR_COUNT, $urandom);
      write_coeff(CSR_COUNT + 1, $urandom);
      verify_coeffs();
      foreach (band_points[i]) begin
         case (i % 3)
            0:       p_raw = '0;
            1:       p_raw = RAW_MAX;
            default: p_raw = RAW_W'($urandom);
         endcase
         send_reading(p_raw, band_points[i]);
      end
      drain();

      // Every calibration word at full scale
      for (int idx = 0; idx < CSR_COUNT; idx++) write_coeff(idx, 32'h0000_FFFF);
      verify_coeffs();
      send_reading('0, '0);
      send_reading(RAW_MAX, '0);
      send_reading('0, RAW_MAX);
      send_reading(RAW_MAX, RAW_MAX);
      drain();

      // Random calibrations and readings; the last phase runs without stalls
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         steady = (phase == RANDOM_PHASES - 1);
         for (int idx = 0; idx < CSR_COUNT; idx++)
            write_coeff(idx, {16'($urandom), pick_coeff()});
         if ($urandom_range(0, 1) == 0) write_coeff(CSR_COUNT + $urandom_range(0, 1), $urandom);
         verify_coeffs();
         repeat (PHASE_ITEMS)
            send_reading(RAW_W'($urandom), pick_temperature(sb.coeff[CSR_REF_TEMP]));
         drain();
      end

      // Catch any stray result items
      repeat (NUM_STAGES * 3) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
